// File: sv/ckvt_pkg.sv
// ----------------------------------------------------------------------------
// ckvt_pkg
// Shared types and codes for the compacting key/value table: word layouts of
// the request and response channels, operation and status codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
package ckvt_pkg;

   // default number of table slots
   localparam int DEFAULT_CAPACITY = 16;

   // operation codes (the unused code acts as a lookup)
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_DUP    = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   // request word
   typedef struct packed {
      logic [1:0]         op;
      logic [15:0]        key;
      logic signed [31:0] value;
   } req_word_type;

   // response word
   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [4:0]         entry_total;
      logic               is_empty;
      logic               is_full;
   } rsp_word_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT
   } state_type;

endpackage

// File: sv/compacting_key_value_table_core.sv
// ----------------------------------------------------------------------------
// compacting_key_value_table_core
// Fixed-capacity key/value table kept packed in insertion order, with lookup,
// insert and delete; a delete closes the gap by moving later slots down.
// ----------------------------------------------------------------------------
// Usage
//   request:  a word on req_data is taken at a clock edge with start high and
//             busy low. busy stays high while the word is being worked on.
//   response: one word per request on rsp_data, shown for exactly one cycle
//             with rsp_valid high; it cannot be held off by the receiver.
//   csr:      csr_data is written into the miss value at an edge with
//             csr_valid high (csr_ready is always high); write it while idle.
// Scan
//   keys and values sit in two single-port-write memories read one slot per
//   cycle, so the response waits for the scan. On an empty table the response
//   comes in the cycle after the request. Otherwise the scan examines the
//   slots in order until a key matches or the last slot is passed, and a
//   delete that hits slot m then moves the count-m-1 later slots down one at
//   a time. busy is low again in the cycle that shows the response, so the
//   next request can be taken there.
// Reset
//   synchronous reset empties the table and clears the miss value; the slot
//   contents are not cleared, since slots past the count are never read.
// ----------------------------------------------------------------------------
module compacting_key_value_table_core
   import ckvt_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  req_word_type       req_data,
   // response channel
   output logic               rsp_valid,
   output rsp_word_type       rsp_data,
   // miss value register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [31:0] csr_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // slot memories
   logic [15:0]        key_ram   [CAPACITY];
   logic signed [31:0] value_ram [CAPACITY];

   // control and item registers
   state_type          state_ff, state_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [1:0]         op_ff;
   logic [15:0]        key_ff;
   logic signed [31:0] value_ff;
   logic signed [31:0] miss_value_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;
   logic [15:0]        key_q_ff;
   logic signed [31:0] value_q_ff;

   // memory access
   logic [AW-1:0]      raddr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [15:0]        wr_key;
   logic signed [31:0] wr_value;

   // current item, taken from the port in the accept cycle
   logic               accept;
   logic [1:0]         cur_op;
   logic [15:0]        cur_key;
   logic signed [31:0] cur_value;

   // finishing decisions
   logic               finish;
   logic               hit;
   logic [1:0]         status_sel;
   logic signed [31:0] read_sel;
   logic [CW-1:0]      count_after;

   // slot arithmetic
   logic [CW:0]        idx_next_ext;
   logic [CW:0]        idx_skip_ext;
   logic [CW:0]        count_ext;
   logic               more_slots;
   logic               more_shift;
   logic               key_match;

   assign accept    = start && (state_ff == S_IDLE);
   assign cur_op    = (state_ff == S_IDLE) ? req_data.op    : op_ff;
   assign cur_key   = (state_ff == S_IDLE) ? req_data.key   : key_ff;
   assign cur_value = (state_ff == S_IDLE) ? req_data.value : value_ff;

   assign idx_next_ext = (CW + 1)'(idx_ff) + (CW + 1)'(1);
   assign idx_skip_ext = (CW + 1)'(idx_ff) + (CW + 1)'(2);
   assign count_ext    = (CW + 1)'(count_ff);
   assign more_slots   = idx_next_ext < count_ext;
   assign more_shift   = idx_skip_ext < count_ext;
   assign key_match    = key_q_ff == key_ff;

   // sequencer: scan one slot a cycle, then move later slots down on delete
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      raddr        = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_key       = key_q_ff;
      wr_value     = value_q_ff;
      finish       = 1'b0;
      hit          = 1'b0;
      status_sel   = ST_DONE;
      read_sel     = miss_value_ff;
      count_after  = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            raddr = '0;
            if (accept) begin
               idx_in = '0;
               if (count_ff != '0) begin
                  state_in = S_SEARCH;
               end else begin
                  // empty table: every key misses, insert always fits
                  finish = 1'b1;
               end
            end
         end
         S_SEARCH: begin
            if (key_match) begin
               hit = 1'b1;
               case (op_ff)
                  OP_INSERT: begin
                     finish     = 1'b1;
                     status_sel = ST_DUP;
                  end
                  OP_DELETE: begin
                     if (more_slots) begin
                        raddr    = AW'(idx_next_ext);
                        state_in = S_SHIFT;
                     end else begin
                        finish      = 1'b1;
                        count_after = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     finish   = 1'b1;
                     read_sel = value_q_ff;
                  end
               endcase
            end else if (more_slots) begin
               raddr  = AW'(idx_next_ext);
               idx_in = AW'(idx_next_ext);
            end else begin
               finish = 1'b1;
            end
         end
         S_SHIFT: begin
            // slot idx takes the word read from slot idx+1
            hit     = 1'b1;
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (more_shift) begin
               raddr  = AW'(idx_skip_ext);
               idx_in = AW'(idx_next_ext);
            end else begin
               finish      = 1'b1;
               count_after = count_ff - CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // miss handling shared by the empty table and the end of a scan
      if (finish && !hit) begin
         case (cur_op)
            OP_INSERT: begin
               if (count_ff >= CW'(CAPACITY)) begin
                  status_sel = ST_FULL;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = AW'(count_ff);
                  wr_key      = cur_key;
                  wr_value    = cur_value;
                  count_after = count_ff + CW'(1);
               end
            end
            OP_DELETE: begin
               status_sel = ST_ABSENT;
            end
            default: begin
               status_sel = ST_DONE;
            end
         endcase
      end

      if (finish) begin
         state_in = S_IDLE;
      end
   end

   // response word
   always_comb begin
      count_in            = count_after;
      rsp_valid_in        = finish;
      rsp_in.found        = hit;
      rsp_in.read_value   = read_sel;
      rsp_in.status       = status_sel;
      rsp_in.entry_total  = 5'(count_after);
      rsp_in.is_empty     = count_after == '0;
      rsp_in.is_full      = count_after == CW'(CAPACITY);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         miss_value_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            miss_value_ff <= csr_data;
         end
      end
   end

   // item and response payload
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         op_ff    <= req_data.op;
         key_ff   <= req_data.key;
         value_ff <= req_data.value;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // slot memories: one write, one registered read per cycle; a slot written
   // at the end of an item is read no earlier than the next item's scan, and
   // a shift writes below the slot it reads, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_ram[wr_addr]   <= wr_key;
         value_ram[wr_addr] <= wr_value;
      end
      key_q_ff   <= key_ram[raddr];
      value_q_ff <= value_ram[raddr];
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

// File: sv/ckvt_checker.sv
// ----------------------------------------------------------------------------
// ckvt_checker
// Port-level checks for the compacting key/value table, bound to the core.
// ----------------------------------------------------------------------------
module ckvt_checker
   import ckvt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_word_type rsp_data
);

   // the response cycle is also the cycle the next word can be taken
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   // an accepted word either answers at once or holds busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither answered nor in progress");

   // busy only rises after a word was taken
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // duplicate means present, absent means not present
   a_status_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.status != ST_DUP || rsp_data.found) &&
                     (rsp_data.status != ST_ABSENT || !rsp_data.found)))
      else $error("status disagrees with found flag");

   // a table cannot be empty and full at once
   a_empty_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_empty && rsp_data.is_full))
      else $error("empty and full both set");

endmodule

bind compacting_key_value_table_core ckvt_checker u_ckvt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// File: tb/sv/compacting_key_value_table_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compacting_key_value_table_core_test
// Self-checking bench for the compacting key/value table. Request words are
// driven through the start/busy handshake. A local copy of the table predicts
// every response word, and a monitor compares each strobed word field by
// field. Directed cases come first, then randomized fill and drain traffic
// under several sender idling patterns and miss value settings.
// ----------------------------------------------------------------------------
module compacting_key_value_table_core_test;
   import ckvt_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
   localparam int POOL_SIZE    = 24;
   localparam int PRINT_LIMIT  = 50;

   // unused operation code, handled as a lookup
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_word_type       req_data = '0;
   logic               rsp_valid;
   rsp_word_type       rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic signed [31:0] csr_data = '0;

   // shadow copy of the table contents and the miss value
   logic [15:0]        shadow_keys [CAPACITY];
   logic signed [31:0] shadow_values [CAPACITY];
   int                 shadow_count = 0;
   logic signed [31:0] shadow_miss = '0;

   rsp_word_type       pending_rsp [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 idle_pct = 0;
   logic [15:0]        key_pool [POOL_SIZE];

   compacting_key_value_table_core #(
      .CAPACITY (CAPACITY)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock generation
   initial begin
      forever #6 clock = ~clock;
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // print one mismatch line and count it
   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // apply one request word to the shadow table and return the response
   function automatic rsp_word_type table_apply(input req_word_type w);
      int           slot;
      int           j;
      rsp_word_type r;
      slot = shadow_count;
      for (int i = shadow_count - 1; i >= 0; i--)
         if (shadow_keys[i] == w.key) slot = i;
      r = '0;
      r.found = (slot < shadow_count);
      r.read_value = shadow_miss;
      r.status = ST_DONE;
      case (w.op)
         OP_INSERT: begin
            if (r.found) begin
               r.status = ST_DUP;
            end else if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               shadow_keys[shadow_count] = w.key;
               shadow_values[shadow_count] = w.value;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            if (!r.found) begin
               r.status = ST_ABSENT;
            end else begin
               // close the gap
               for (j = slot; j + 1 < shadow_count; j++) begin
                  shadow_keys[j] = shadow_keys[j + 1];
                  shadow_values[j] = shadow_values[j + 1];
               end
               shadow_count--;
            end
         end
         default: begin
            if (r.found) r.read_value = shadow_values[slot];
         end
      endcase
      r.entry_total = 5'(shadow_count);
      r.is_empty = (shadow_count == 0);
      r.is_full = (shadow_count == CAPACITY);
      return r;
   endfunction

   // send one request word, optionally idle afterwards
   task automatic send_word(input logic [1:0] op, input logic [15:0] key,
                            input logic signed [31:0] value);
      req_word_type w;
      int           gap;
      w.op = op;
      w.key = key;
      w.value = value;
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(table_apply(w));
      if ($urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait for every pending response
   task automatic wait_idle;
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   // write the miss value register while the table is idle
   task automatic write_miss_value(input logic signed [31:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_miss = v;
   endtask

   // response checker
   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected response word %h", rsp_data));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %b, want %b", rsp_data.found, want.found));
            if (rsp_data.read_value !== want.read_value)
               report_mismatch($sformatf("read_value %h, want %h",
                                         rsp_data.read_value, want.read_value));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_data.status, want.status));
            if (rsp_data.entry_total !== want.entry_total)
               report_mismatch($sformatf("entry_total %0d, want %0d",
                                         rsp_data.entry_total, want.entry_total));
            if (rsp_data.is_empty !== want.is_empty)
               report_mismatch($sformatf("is_empty %b, want %b",
                                         rsp_data.is_empty, want.is_empty));
            if (rsp_data.is_full !== want.is_full)
               report_mismatch($sformatf("is_full %b, want %b", rsp_data.is_full, want.is_full));
         end
      end
   end

   // empty table, key and value extremes, fill to full, deletes at the ends
   task automatic test_directed_cases;
      idle_pct = 0;
      send_word(OP_LOOKUP, 16'h1234, 32'sd5);           // lookup in empty table
      send_word(OP_DELETE, 16'h1234, '0);               // delete from empty table
      send_word(OP_UNUSED, 16'hffff, '0);               // unused code on empty table
      send_word(OP_INSERT, 16'h0000, 32'h8000_0000);
      send_word(OP_INSERT, 16'hffff, 32'h7fff_ffff);
      send_word(OP_INSERT, 16'h0000, 32'sd1);           // duplicate key
      send_word(OP_LOOKUP, 16'h0000, '1);
      send_word(OP_UNUSED, 16'hffff, '1);               // unused code hits
      for (int i = 2; i < CAPACITY; i++)
         send_word(OP_INSERT, 16'(16'h5a00 + i), $urandom());
      send_word(OP_INSERT, 16'h1234, $urandom());       // new key on full table
      send_word(OP_INSERT, 16'hffff, $urandom());       // duplicate on full table
      send_word(OP_DELETE, 16'(16'h5a00 + CAPACITY - 1), '0);  // last slot
      send_word(OP_DELETE, 16'h0000, '0);               // first slot, all shift
      send_word(OP_LOOKUP, 16'h5a05, '0);
      send_word(OP_DELETE, 16'h5a07, '0);               // middle slot
   endtask

   // miss value extremes seen by misses, hits and writes
   task automatic test_miss_value_register;
      idle_pct = 0;
      write_miss_value(32'h8000_0000);
      send_word(OP_LOOKUP, 16'h4321, '0);
      send_word(OP_DELETE, 16'h4321, '0);
      send_word(OP_INSERT, 16'h4321, 32'sd77);
      write_miss_value(32'h7fff_ffff);
      send_word(OP_LOOKUP, 16'h4321, '0);
      send_word(OP_UNUSED, 16'h9999, '0);
      send_word(OP_INSERT, 16'h4321, 32'sd78);
      write_miss_value('1);
      send_word(OP_LOOKUP, 16'h0001, '0);
   endtask

   // random fill and drain traffic at a given sender idle rate
   task automatic test_random_traffic(input int pct, input int count,
                                      input logic signed [31:0] miss);
      int          fill_bias;
      int          roll;
      int          pick;
      logic [1:0]  op;
      logic [15:0] key;
      write_miss_value(miss);
      idle_pct = pct;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom_range(65535));
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hffff;
      fill_bias = 60;
      for (int n = 0; n < count; n++) begin
         // alternate stretches that fill and that drain the table
         if (n % 40 == 0) fill_bias = $urandom_range(1) ? 60 : 25;
         roll = $urandom_range(99);
         if (roll < 5) op = OP_UNUSED;
         else if (roll < 5 + fill_bias) op = OP_INSERT;
         else if (roll % 2 == 0) op = OP_LOOKUP;
         else op = OP_DELETE;
         pick = $urandom_range(99);
         if (shadow_count > 0 && pick < 45)
            key = shadow_keys[$urandom_range(shadow_count - 1)];
         else if (pick < 90)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
         else
            key = 16'($urandom_range(65535));
         send_word(op, key, $urandom());
      end
   endtask

   // test sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_miss_value_register();
      test_random_traffic(0, 270, $urandom());
      test_random_traffic(63, 270, 32'h8000_0000);
      test_random_traffic(14, 270, $urandom());
      test_random_traffic(0, 250, '0);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
